// File: rtl/apc_pkg.sv
// apc_pkg: shared types and fixed-point constants for the altitude PID controller.
// No dependencies; imported by every module under rtl/.
package apc_pkg;

    localparam int ALT_W   = 16;
    localparam int ERR_W   = 17;
    localparam int DERR_W  = 18;
    localparam int GAIN_W  = 24;
    localparam int CMD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Gains carry this many fraction bits.
    localparam int GAIN_FRAC_BITS = 8;

    // Datapath widths, all signed.
    localparam int PROD_W  = GAIN_W + ERR_W;    // kp*e, ki*e
    localparam int DPROD_W = GAIN_W + DERR_W;   // kd*(e - e_prev)
    localparam int P10_W   = PROD_W + 4;
    localparam int D100_W  = DPROD_W + 7;
    localparam int INTEG_W = 48;
    localparam int NUM_W   = 51;

    // cmd = floor(num * 2^15 / (100000 * 2^F)) = floor(num * 2^(10-F) / 3125).
    // Valid for F <= 10; the scaled numerator is offset so it is never negative
    // inside the unsaturated window.
    localparam int SCALE_SHIFT = 10 - GAIN_FRAC_BITS;
    localparam longint DEN     = 64'd100000 * (64'd1 << GAIN_FRAC_BITS);
    localparam longint X_OFFSET = 64'd102400000;     // DEN << SCALE_SHIFT
    localparam int X_W         = 28;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 40;
    localparam logic [RECIP_W-1:0] RECIP_3125 = 29'd351843721;  // ceil(2^40 / 3125)
    localparam int MUL_W       = X_W + RECIP_W;

    localparam logic signed [NUM_W-1:0] NUM_HI = NUM_W'(DEN);
    localparam logic signed [NUM_W-1:0] NUM_LO = -NUM_W'(DEN);
    localparam logic signed [NUM_W-1:0] NUM_OFF = NUM_W'(X_OFFSET);

    localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sh7FFF;
    localparam logic signed [CMD_W-1:0] CMD_MIN = 16'sh8000;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 2'd0,
        REG_PROP   = 2'd1,
        REG_INTEG  = 2'd2,
        REG_DERIV  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
    } gains_t;

    // One classified sample waiting for the arithmetic back end.
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
    } sample_t;

endpackage

// File: rtl/apc_front.sv
// apc_front: accepts altitude samples, forms error and error delta, keeps last error.
// Depends on apc_pkg.
module apc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [apc_pkg::ALT_W-1:0] s_measured_altitude,
    input  logic [apc_pkg::ALT_W-1:0] target_altitude,
    input  logic                      q_full,
    output logic                      q_push,
    output apc_pkg::sample_t          q_wdata
);
    import apc_pkg::*;

    logic signed [ERR_W-1:0] last_err_reg;
    logic signed [ERR_W-1:0] err;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    assign err          = $signed({1'b0, target_altitude}) - $signed({1'b0, s_measured_altitude});
    assign q_wdata.err  = err;
    assign q_wdata.derr = DERR_W'(err) - DERR_W'(last_err_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (q_push) begin
            last_err_reg <= err;
        end
    end

endmodule

// File: rtl/apc_queue.sv
// apc_queue: small register FIFO between front and back ends.
// Depends on apc_pkg. DEPTH must be at least 2.
module apc_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  apc_pkg::sample_t wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output apc_pkg::sample_t rdata
);
    import apc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sample_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue pushed while full");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue occupancy lost a transfer");

endmodule

// File: rtl/apc_back.sv
// apc_back: PID arithmetic pipeline with integral state, scaling and saturation.
// Depends on apc_pkg. Stages: products, integral update, sum, window check,
// reciprocal multiply, output register. The whole pipe advances on one enable.
module apc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  apc_pkg::gains_t                   gains,
    input  logic                              q_not_empty,
    input  apc_pkg::sample_t                  q_rdata,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [apc_pkg::CMD_W-1:0]  m_velocity_command,
    output logic signed [apc_pkg::ERR_W-1:0]  m_height_error
);
    import apc_pkg::*;

    logic en;

    // stage 1: products
    logic                      b1_valid_reg;
    logic signed [PROD_W-1:0]  b1_p_reg;
    logic signed [PROD_W-1:0]  b1_i_reg;
    logic signed [DPROD_W-1:0] b1_d_reg;
    logic signed [ERR_W-1:0]   b1_err_reg;

    // stage 2: scaled P and D; integ_reg is both state and stage value
    logic                      b2_valid_reg;
    logic signed [P10_W-1:0]   b2_p10_reg;
    logic signed [D100_W-1:0]  b2_d100_reg;
    logic signed [ERR_W-1:0]   b2_err_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_next;

    // stage 3: numerator
    logic                      b3_valid_reg;
    logic signed [NUM_W-1:0]   b3_num_reg;
    logic signed [ERR_W-1:0]   b3_err_reg;

    // stage 4: window check and offset numerator
    logic                      b4_valid_reg;
    logic                      b4_sat_hi_reg;
    logic                      b4_sat_lo_reg;
    logic [X_W-1:0]            b4_x_reg;
    logic signed [ERR_W-1:0]   b4_err_reg;
    logic signed [NUM_W-1:0]   x_full;

    // stage 5: reciprocal product
    logic                      b5_valid_reg;
    logic                      b5_sat_hi_reg;
    logic                      b5_sat_lo_reg;
    logic [MUL_W-1:0]          b5_mul_reg;
    logic signed [ERR_W-1:0]   b5_err_reg;
    logic [CMD_W-1:0]          quot;

    logic                      out_valid_reg;
    logic signed [CMD_W-1:0]   out_cmd_reg;
    logic signed [ERR_W-1:0]   out_err_reg;

    assign en    = !out_valid_reg || m_ready;
    assign q_pop = en && q_not_empty;

    assign integ_sum  = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(b1_i_reg);
    // overflow when the two top bits disagree
    assign integ_next = (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) ?
                        (integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX) :
                        integ_sum[INTEG_W-1:0];

    assign x_full = (b3_num_reg <<< SCALE_SHIFT) + NUM_OFF;
    // floor(x / 3125), offset by 32768; flip the top bit to remove the offset
    assign quot   = b5_mul_reg[RECIP_SHIFT +: CMD_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_p_reg   <= PROD_W'(gains.prop_gain) * PROD_W'(q_rdata.err);
            b1_i_reg   <= PROD_W'(gains.integ_gain) * PROD_W'(q_rdata.err);
            b1_d_reg   <= DPROD_W'(gains.deriv_gain) * DPROD_W'(q_rdata.derr);
            b1_err_reg <= q_rdata.err;

            b2_p10_reg  <= (P10_W'(b1_p_reg) <<< 3) + (P10_W'(b1_p_reg) <<< 1);
            b2_d100_reg <= (D100_W'(b1_d_reg) <<< 6) + (D100_W'(b1_d_reg) <<< 5)
                         + (D100_W'(b1_d_reg) <<< 2);
            b2_err_reg  <= b1_err_reg;

            b3_num_reg <= NUM_W'(b2_p10_reg) + NUM_W'(b2_d100_reg) + NUM_W'(integ_reg);
            b3_err_reg <= b2_err_reg;

            b4_sat_hi_reg <= (b3_num_reg >= NUM_HI);
            b4_sat_lo_reg <= (b3_num_reg < NUM_LO);
            b4_x_reg      <= x_full[X_W-1:0];
            b4_err_reg    <= b3_err_reg;

            b5_sat_hi_reg <= b4_sat_hi_reg;
            b5_sat_lo_reg <= b4_sat_lo_reg;
            b5_mul_reg    <= MUL_W'(b4_x_reg) * MUL_W'(RECIP_3125);
            b5_err_reg    <= b4_err_reg;

            if (b5_sat_hi_reg) begin
                out_cmd_reg <= CMD_MAX;
            end else if (b5_sat_lo_reg) begin
                out_cmd_reg <= CMD_MIN;
            end else begin
                out_cmd_reg <= $signed({~quot[CMD_W-1], quot[CMD_W-2:0]});
            end
            out_err_reg <= b5_err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
        end else if (en) begin
            b1_valid_reg  <= q_not_empty;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            out_valid_reg <= b5_valid_reg;
            if (b1_valid_reg) begin
                integ_reg <= integ_next;
            end
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_velocity_command = out_cmd_reg;
    assign m_height_error     = out_err_reg;

    a_integ_only_on_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(en && b1_valid_reg) |=> $stable(integ_reg))
        else $error("integral changed without an item");

    a_sat_hi_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && b5_valid_reg && b5_sat_hi_reg) |=> (m_valid && m_velocity_command == CMD_MAX))
        else $error("positive saturation not applied");

    a_sat_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        b4_valid_reg |-> !(b4_sat_hi_reg && b4_sat_lo_reg))
        else $error("both saturation flags set");

endmodule

// File: rtl/altitude_pid_controller.sv
// altitude_pid_controller: top level, configuration registers and front/queue/back.
// Depends on apc_pkg, apc_front, apc_queue, apc_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | s_valid / s_ready    | s_measured_altitude [15:0] unsigned
//  result   | m_valid / m_ready    | m_velocity_command [15:0] s, m_height_error [16:0] s
//  config   | cfg_wr_en            | cfg_index [1:0], cfg_data [23:0]
//
// One sample per cycle sustained while m_ready is high, through queue and back pipe.
// The rate is bounded by the integral accumulator: one 49-bit add and clamp per cycle.
// Reset (synchronous, aresetn low) clears gains, setpoint, integral, last error, queue.
// A stalled result holds the back pipe; the front keeps taking samples until the
// queue of QUEUE_DEPTH entries fills.
module altitude_pid_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [apc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [apc_pkg::ALT_W-1:0]         s_measured_altitude,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [apc_pkg::CMD_W-1:0]  m_velocity_command,
    output logic signed [apc_pkg::ERR_W-1:0]  m_height_error
);
    import apc_pkg::*;

    logic [ALT_W-1:0] target_reg;
    gains_t           gains_reg;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_not_empty;
    sample_t q_wdata;
    sample_t q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            gains_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET: target_reg            <= cfg_data[ALT_W-1:0];
                REG_PROP:   gains_reg.prop_gain   <= $signed(cfg_data[GAIN_W-1:0]);
                REG_INTEG:  gains_reg.integ_gain  <= $signed(cfg_data[GAIN_W-1:0]);
                REG_DERIV:  gains_reg.deriv_gain  <= $signed(cfg_data[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    apc_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_measured_altitude (s_measured_altitude),
        .target_altitude     (target_reg),
        .q_full              (q_full),
        .q_push              (q_push),
        .q_wdata             (q_wdata)
    );

    apc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    apc_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .gains              (gains_reg),
        .q_not_empty        (q_not_empty),
        .q_rdata            (q_rdata),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_velocity_command (m_velocity_command),
        .m_height_error     (m_height_error)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for altitude_pid_controller (directed, random and windup runs).
// Depends on apc_pkg and the altitude_pid_controller RTL; carries its own PID predictor.

module tb;

    localparam longint CMD_DEN   = 64'sd100000 * 64'sd256;   // 0.1 s tick, 8 gain fraction bits
    localparam longint INTEG_HI  = (64'sd1 <<< 47) - 1;
    localparam longint INTEG_LO  = -(64'sd1 <<< 47);
    localparam int     TAIL_CYC  = 10;
    localparam int     MAX_SHOWN = 40;

    typedef struct packed {
        logic signed [15:0] cmd;
        logic signed [16:0] err;
    } pid_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    apc_pkg::cfg_reg_t   cfg_index = apc_pkg::REG_TARGET;
    logic [23:0]         cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [15:0]         s_measured_altitude = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [15:0]  m_velocity_command;
    logic signed [16:0]  m_height_error;

    // predictor state and register shadow
    logic [15:0]         mdl_target = '0;
    logic signed [23:0]  mdl_kp = '0;
    logic signed [23:0]  mdl_ki = '0;
    logic signed [23:0]  mdl_kd = '0;
    longint              mdl_integral = 0;
    longint              mdl_last_err = 0;

    pid_result_t         expected_commands[$];
    int                  n_errors = 0;
    int                  n_samples = 0;
    int                  n_checked = 0;
    int                  n_clip_hi = 0;
    int                  n_clip_lo = 0;
    int                  n_writes = 0;
    int                  burst_left = 0;
    int                  rx_hold_req = 0;

    altitude_pid_controller i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_measured_altitude (s_measured_altitude),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_velocity_command  (m_velocity_command),
        .m_height_error      (m_height_error)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("timeout: %0d of %0d samples checked", n_checked, n_samples);
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_SHOWN)
            $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // PID step at one tick: integral clamps to 48 bits, command floors then clips to Q1.15
    function automatic pid_result_t predict_pid_output(input logic [15:0] alt);
        pid_result_t res;
        longint e, de, num, q, r, cmd;
        e = longint'(mdl_target) - longint'(alt);
        de = e - mdl_last_err;
        mdl_integral = mdl_integral + longint'(mdl_ki) * e;
        if (mdl_integral > INTEG_HI) mdl_integral = INTEG_HI;
        else if (mdl_integral < INTEG_LO) mdl_integral = INTEG_LO;
        mdl_last_err = e;
        num = 10 * longint'(mdl_kp) * e + mdl_integral + 100 * longint'(mdl_kd) * de;
        q = num / CMD_DEN;
        r = num % CMD_DEN;
        if (r < 0) begin
            r += CMD_DEN;
            q -= 1;
        end
        if (q >= 1) cmd = 32767;
        else if (q < -1) cmd = -32768;
        else cmd = q * 32768 + (r * 32768) / CMD_DEN;
        res.cmd = cmd[15:0];
        res.err = e[16:0];
        return res;
    endfunction

    function automatic logic [23:0] rand_gain(input int cls, input int spread);
        case (cls)
            0: return 24'd0;
            1: return 24'(int'($urandom_range(0, 2 * spread)) - spread);
            2: return 24'($urandom);
            default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    task automatic write_reg(input apc_pkg::cfg_reg_t idx, input logic [23:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            apc_pkg::REG_TARGET: mdl_target = data[15:0];
            apc_pkg::REG_PROP:   mdl_kp = data;
            apc_pkg::REG_INTEG:  mdl_ki = data;
            apc_pkg::REG_DERIV:  mdl_kd = data;
            default: ;
        endcase
        n_writes++;
    endtask

    // upper data bits on the setpoint write are junk and must be dropped
    task automatic apply_config(input logic [15:0] setpoint, input logic [23:0] kp,
                                input logic [23:0] ki, input logic [23:0] kd);
        write_reg(apc_pkg::REG_TARGET, {8'($urandom), setpoint});
        write_reg(apc_pkg::REG_PROP, kp);
        write_reg(apc_pkg::REG_INTEG, ki);
        write_reg(apc_pkg::REG_DERIV, kd);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] alt);
        s_valid <= 1'b1;
        s_measured_altitude <= alt;
        do @(posedge aclk); while (!s_ready);
        expected_commands.push_back(predict_pid_output(alt));
        n_samples++;
    endtask

    task automatic pace_sender(input int gap_max);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_commands.size() != 0) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);
    endtask

    task automatic test_reset_state();
        wait_results_drained();
        send_sample(16'd0);
    endtask

    // derivative sees the whole first nonzero error since last error is still zero
    task automatic test_first_tick();
        wait_results_drained();
        apply_config(16'd1000, 24'd256, 24'd0, 24'd3);
        send_sample(16'd900);
        send_sample(16'd1000);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd1001);
        send_sample(16'd999);
    endtask

    task automatic test_command_limits();
        wait_results_drained();
        apply_config(16'hFFFF, 24'h7FFFFF, 24'd0, 24'd0);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);
        wait_results_drained();
        apply_config(16'd0, 24'h800000, 24'd0, 24'h7FFFFF);
        send_sample(16'hFFFF);
        send_sample(16'd0);
    endtask

    // kp = 10.0: error 1000 lands exactly on +1.0, small negatives floor downward
    task automatic test_floor_rounding();
        wait_results_drained();
        apply_config(16'd30000, 24'd2560, 24'd0, 24'd0);
        send_sample(16'd29000);
        send_sample(16'd31000);
        send_sample(16'd29001);
        send_sample(16'd30001);
        send_sample(16'd31001);
        send_sample(16'd30000);
    endtask

    task automatic test_random_tracking();
        logic [15:0] setpoint;
        logic [23:0] ki;
        int span, gap_max, off, v;
        for (int ph = 0; ph < 6; ph++) begin
            wait_results_drained();
            case ($urandom_range(0, 3))
                0: setpoint = 16'd0;
                1: setpoint = 16'hFFFF;
                default: setpoint = 16'($urandom);
            endcase
            // keep the integral near zero until the last phase so commands stay in range
            if (ph < 5) ki = rand_gain($urandom_range(0, 1), 16);
            else ki = rand_gain($urandom_range(2, 3), 0);
            apply_config(setpoint, rand_gain($urandom_range(0, 3), 2048), ki,
                         rand_gain($urandom_range(0, 3), 256));
            case ($urandom_range(0, 2))
                0: span = 64;
                1: span = 2000;
                default: span = 65535;
            endcase
            gap_max = (ph % 2) ? 0 : $urandom_range(1, 6);
            for (int i = 0; i < 70; i++) begin
                if (ph == 2 && i == 10) rx_hold_req = 300;
                if (ph == 4 && i == 35) wait_results_drained();
                if ($urandom_range(0, 4) == 0) begin
                    v = $urandom_range(0, 65535);
                end else begin
                    off = int'($urandom_range(0, 2 * span)) - span;
                    v = int'(setpoint) + off;
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                end
                send_sample(16'(v));
                pace_sender(gap_max);
            end
        end
    endtask

    task automatic wind_integral_to(input longint rail, input int alt_lo, input int alt_hi);
        int at_rail;
        at_rail = 0;
        while (at_rail < 15) begin
            send_sample(16'($urandom_range(alt_lo, alt_hi)));
            if (mdl_integral == rail) at_rail++;
            pace_sender(4);
        end
    endtask

    // full-scale gain and error drive the integral into each rail and back across zero
    task automatic test_integral_windup();
        wait_results_drained();
        apply_config(16'hFFFF, rand_gain(2, 0), 24'h7FFFFF, rand_gain(2, 0));
        wind_integral_to(INTEG_HI, 0, 255);
        wait_results_drained();
        apply_config(16'd0, rand_gain(2, 0), 24'h7FFFFF, rand_gain(1, 256));
        wind_integral_to(INTEG_LO, 65280, 65535);
        wait_results_drained();
        apply_config(16'd0, rand_gain(1, 2048), 24'h800000, rand_gain(2, 0));
        wind_integral_to(INTEG_HI, 65280, 65535);
    endtask

    // receiver: segments of random stall density, plus an on-demand long hold-off
    initial begin : rx_pattern
        int seg_left, stall_pct, hold_left;
        seg_left = 0;
        stall_pct = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 150);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        pid_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_commands.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer cmd %0d err %0d",
                                          m_velocity_command, m_height_error));
            end else begin
                want = expected_commands.pop_front();
                if (m_velocity_command !== want.cmd)
                    report_mismatch($sformatf("result %0d velocity_command %0d, want %0d",
                                              n_checked, m_velocity_command, want.cmd));
                if (m_height_error !== want.err)
                    report_mismatch($sformatf("result %0d height_error %0d, want %0d",
                                              n_checked, m_height_error, want.err));
                if (want.cmd == 16'sh7FFF) n_clip_hi++;
                if (want.cmd == 16'sh8000) n_clip_lo++;
            end
            n_checked++;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_first_tick();
        test_command_limits();
        test_floor_rounding();
        test_random_tracking();
        test_integral_windup();
        wait_results_drained();
        $display("covered %0d altitude samples and %0d register writes; %0d commands checked",
                 n_samples, n_writes, n_checked);
        $display("commands at +1 limit: %0d, at -1 limit: %0d, mismatches: %0d",
                 n_clip_hi, n_clip_lo, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
